### sv/rbb_pkg.sv
// Shared types, constants and the rounding function of the rotated bounding box.
package rbb_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W   = 8;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COS = 8'd0,
    REG_SIN = 8'd1
  } cfg_reg_e;

  // One rotated and rounded point, as it travels through the queue
  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic               last;
  } rot_point_t;

  localparam logic signed [65:0] HALF_Q30    = 66'sd536870912;
  localparam logic signed [65:0] HALF_Q30_M1 = 66'sd536870911;
  localparam logic signed [35:0] POS_LIMIT   = 36'sd4294967295;
  localparam logic signed [35:0] NEG_LIMIT   = -36'sd4294967296;

  // Round a Q30 sum to integer, ties away from zero, and saturate to 33 bits
  function automatic logic signed [32:0] round_sat(input logic signed [64:0] u);
    logic signed [65:0] adj;
    logic signed [35:0] r;
    logic signed [32:0] res;
    // a negative sum rounds as floor((u + 2^29 - 1) / 2^30)
    adj = {u[64], u} + (u[64] ? HALF_Q30_M1 : HALF_Q30);
    r   = adj[65:30];
    if (r > POS_LIMIT) begin
      res = POS_LIMIT[32:0];
    end else if (r < NEG_LIMIT) begin
      res = NEG_LIMIT[32:0];
    end else begin
      res = r[32:0];
    end
    return res;
  endfunction

endpackage

### sv/rbb_front.sv
// Front end: takes points, rotates them, rounds and pushes them into the queue.
module rbb_front
  import rbb_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [31:0]                 cfg_data,
  input  logic                        point_valid,
  output logic                        point_stall,
  input  logic signed [31:0]          point_x,
  input  logic signed [31:0]          point_y,
  input  logic                        last_point,
  input  logic [QCNT_W-1:0]           queue_count,
  output logic                        push,
  output rot_point_t                  push_data
);

  logic signed [31:0] cos_angle;
  logic signed [31:0] sin_angle;

  // stage 1: products
  logic               s1_valid;
  logic               s1_last;
  logic signed [63:0] s1_cx, s1_cy, s1_sx, s1_sy;

  // stage 2: exact sums
  logic               s2_valid;
  logic               s2_last;
  logic signed [64:0] s2_rx, s2_ry;

  logic               accept;
  logic [QCNT_W:0]    committed;

  // Hold the angle registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cos_angle <= 32'sh4000_0000;
      sin_angle <= 32'sh0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_COS) begin
        cos_angle <= cfg_data;
      end else if (cfg_index == REG_SIN) begin
        sin_angle <= cfg_data;
      end
    end
  end

  // Take a point only while the queue has room for everything in flight
  always_comb begin
    committed   = {1'b0, queue_count} + (QCNT_W+1)'(s1_valid) + (QCNT_W+1)'(s2_valid);
    point_stall = (committed >= (QCNT_W+1)'(QUEUE_DEPTH));
    accept      = point_valid && !point_stall;
  end

  // Advance the pipeline valids; stages never stall
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
    end
  end

  // Multiply, then form the exact rotated sums
  always_ff @(posedge clk) begin
    s1_last <= last_point;
    s1_cx   <= cos_angle * point_x;
    s1_cy   <= cos_angle * point_y;
    s1_sx   <= sin_angle * point_x;
    s1_sy   <= sin_angle * point_y;
    s2_last <= s1_last;
    s2_rx   <= {s1_cx[63], s1_cx} - {s1_sy[63], s1_sy};
    s2_ry   <= {s1_cy[63], s1_cy} + {s1_sx[63], s1_sx};
  end

  // Round and push
  always_comb begin
    push           = s2_valid;
    push_data.x    = round_sat(s2_rx);
    push_data.y    = round_sat(s2_ry);
    push_data.last = s2_last;
  end

endmodule

### sv/rbb_queue.sv
// Short queue of rotated points between the front and back ends.
module rbb_queue
  import rbb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rot_point_t        push_data,
  input  logic              pop,
  output rot_point_t        head,
  output logic              empty,
  output logic [QCNT_W-1:0] count
);

  rot_point_t        entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  // Write the new entry
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  assign head  = entries[rd_ptr];
  assign empty = (count == '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != QCNT_W'(QUEUE_DEPTH)))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("queue pop while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

### sv/rbb_back.sv
// Back end: folds rotated points into the running box and emits it on the last point.
module rbb_back
  import rbb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  rot_point_t         head,
  input  logic               empty,
  output logic               pop,
  output logic               box_valid,
  input  logic               box_stall,
  output logic signed [32:0] box_min_x,
  output logic signed [32:0] box_min_y,
  output logic signed [32:0] box_max_x,
  output logic signed [32:0] box_max_y
);

  logic               have_first;
  logic signed [32:0] run_min_x, run_min_y, run_max_x, run_max_y;
  logic signed [32:0] min_x_next, min_y_next, max_x_next, max_y_next;
  logic               slot_free;

  // Pop a point unless it closes a set and the output slot is still full
  always_comb begin
    slot_free = !box_valid || !box_stall;
    pop       = !empty && (!head.last || slot_free);
  end

  // Merge the head point into the bounds; the first point seeds them
  always_comb begin
    if (!have_first) begin
      min_x_next = head.x;
      max_x_next = head.x;
      min_y_next = head.y;
      max_y_next = head.y;
    end else begin
      min_x_next = (head.x < run_min_x) ? head.x : run_min_x;
      max_x_next = (head.x > run_max_x) ? head.x : run_max_x;
      min_y_next = (head.y < run_min_y) ? head.y : run_min_y;
      max_y_next = (head.y > run_max_y) ? head.y : run_max_y;
    end
  end

  // Track whether a set is open
  always_ff @(posedge clk) begin
    if (rst) begin
      have_first <= 1'b0;
    end else if (pop) begin
      have_first <= !head.last;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      run_min_x <= min_x_next;
      run_max_x <= max_x_next;
      run_min_y <= min_y_next;
      run_max_y <= max_y_next;
    end
  end

  // Output register: load on the last point, drop once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      box_valid <= 1'b0;
    end else if (pop && head.last) begin
      box_valid <= 1'b1;
    end else if (!box_stall) begin
      box_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      box_min_x <= min_x_next;
      box_min_y <= min_y_next;
      box_max_x <= max_x_next;
      box_max_y <= max_y_next;
    end
  end

endmodule

### sv/rotated_bounding_box_top.sv
// Rotated bounding box: one point per cycle unless point_stall, one box per point set.
// Path: the transfer edge captures the products; the sums are registered, rounded into
// the queue, and folded into the output register, which then raises box_valid.
// Throughput: one point per cycle while point_stall is low, set by the min/max fold.
// Reset: rst, synchronous; restores cos 1.0 and sin 0, empties the queue, closes any set.
module rotated_bounding_box_top
  import rbb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 point_valid,
  output logic                 point_stall,
  input  logic signed [31:0]   point_x,
  input  logic signed [31:0]   point_y,
  input  logic                 last_point,
  output logic                 box_valid,
  input  logic                 box_stall,
  output logic signed [32:0]   box_min_x,
  output logic signed [32:0]   box_min_y,
  output logic signed [32:0]   box_max_x,
  output logic signed [32:0]   box_max_y
);

  logic              push;
  rot_point_t        push_data;
  logic              pop;
  rot_point_t        head;
  logic              empty;
  logic [QCNT_W-1:0] queue_count;

  // Registers accept a write in every cycle
  assign cfg_ready = 1'b1;

  rbb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .point_x     (point_x),
    .point_y     (point_y),
    .last_point  (last_point),
    .queue_count (queue_count),
    .push        (push),
    .push_data   (push_data)
  );

  rbb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .count     (queue_count)
  );

  rbb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .box_valid (box_valid),
    .box_stall (box_stall),
    .box_min_x (box_min_x),
    .box_min_y (box_min_y),
    .box_max_x (box_max_x),
    .box_max_y (box_max_y)
  );

endmodule

### tb/sv/tb_rotated_bounding_box_top.sv
// Self-checking testbench for the rotated bounding box: directed and random point sets.
`timescale 1ns / 1ps

module tb_rotated_bounding_box_top;
  import rbb_pkg::*;

  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int DRAIN_CYCLES     = 8;
  localparam int RANDOM_PHASES    = 10;
  localparam int POINTS_PER_PHASE = 165;
  localparam int REPORT_LIMIT     = 10;

  // Register indexes that decode to nothing
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] IDX_TOP   = 8'hFF;

  // Q2.30 angle values and 32-bit extremes
  localparam logic [31:0] Q30_ONE       = 32'h4000_0000;
  localparam logic [31:0] Q30_MINUS_ONE = 32'hC000_0000;
  localparam logic [31:0] Q30_HALF      = 32'h2000_0000;
  localparam logic [31:0] Q30_MINUS_HALF = 32'hE000_0000;
  localparam logic [31:0] Q30_COS_45    = 32'd759250125;
  localparam logic [31:0] Q30_COS_30    = 32'd929887697;
  localparam logic [31:0] WORD_MAX      = 32'h7FFF_FFFF;
  localparam logic [31:0] WORD_MIN      = 32'h8000_0000;

  localparam logic signed [65:0] ROUND_HALF = 66'sd536870912;
  localparam logic signed [65:0] BOX_HIGH   = 66'sd4294967295;
  localparam logic signed [65:0] BOX_LOW    = -66'sd4294967296;

  typedef struct packed {
    logic signed [32:0] min_x;
    logic signed [32:0] min_y;
    logic signed [32:0] max_x;
    logic signed [32:0] max_y;
  } box_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;
  logic                 point_valid = 1'b0;
  logic                 point_stall;
  logic signed [31:0]   point_x = '0;
  logic signed [31:0]   point_y = '0;
  logic                 last_point = 1'b0;
  logic                 box_valid;
  logic                 box_stall = 1'b0;
  logic signed [32:0]   box_min_x;
  logic signed [32:0]   box_min_y;
  logic signed [32:0]   box_max_x;
  logic signed [32:0]   box_max_y;

  // Shadow of the block: angle registers and the open set
  logic signed [31:0] cos_q30 = Q30_ONE;
  logic signed [31:0] sin_q30 = '0;
  logic signed [32:0] span_min_x = '0;
  logic signed [32:0] span_min_y = '0;
  logic signed [32:0] span_max_x = '0;
  logic signed [32:0] span_max_y = '0;
  logic               set_open = 1'b0;
  box_t               expected_boxes[$];

  int errors = 0;
  int points_sent = 0;
  int boxes_checked = 0;
  int angles_used = 0;
  int idle_cycles = 0;
  bit point_idle_en = 1'b1;
  bit box_idle_en = 1'b1;

  rotated_bounding_box_top dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .point_x     (point_x),
    .point_y     (point_y),
    .last_point  (last_point),
    .box_valid   (box_valid),
    .box_stall   (box_stall),
    .box_min_x   (box_min_x),
    .box_min_y   (box_min_y),
    .box_max_x   (box_max_x),
    .box_max_y   (box_max_y)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Count a failure; print only the first few
  function automatic void note_error(input string msg);
    errors++;
    if (errors <= REPORT_LIMIT) $display("ERROR at %0t: %s", $realtime, msg);
  endfunction

  // Mostly no gap, some short, a few long
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Divide an exact Q30 sum by 2^30, round half away from zero, clamp to 33 bits
  function automatic logic signed [32:0] round_q30_sat(input logic signed [65:0] sum);
    logic signed [65:0] q;
    if (sum < 0) q = -((-sum + ROUND_HALF) >>> 30);
    else q = (sum + ROUND_HALF) >>> 30;
    if (q > BOX_HIGH) q = BOX_HIGH;
    else if (q < BOX_LOW) q = BOX_LOW;
    return q[32:0];
  endfunction

  // Rotate one point, fold it into the open set, close the set on the last point
  function automatic void fold_point(input logic signed [31:0] px, input logic signed [31:0] py,
                                     input logic last);
    logic signed [65:0] c, s, x, y;
    logic signed [32:0] rx, ry;
    c = cos_q30;
    s = sin_q30;
    x = px;
    y = py;
    rx = round_q30_sat(c * x - s * y);
    ry = round_q30_sat(c * y + s * x);
    if (!set_open) begin
      span_min_x = rx;
      span_max_x = rx;
      span_min_y = ry;
      span_max_y = ry;
      set_open = 1'b1;
    end else begin
      if (rx < span_min_x) span_min_x = rx;
      if (rx > span_max_x) span_max_x = rx;
      if (ry < span_min_y) span_min_y = ry;
      if (ry > span_max_y) span_max_y = ry;
    end
    if (last) begin
      expected_boxes.push_back('{span_min_x, span_min_y, span_max_x, span_max_y});
      span_min_x = '0;
      span_min_y = '0;
      span_max_x = '0;
      span_max_y = '0;
      set_open = 1'b0;
    end
  endfunction

  // Hold one point until it transfers, then update the shadow
  task automatic send_point(input logic [31:0] px, input logic [31:0] py, input logic last);
    int gap;
    gap = point_idle_en ? idle_gap() : 0;
    if (gap > 0) begin
      point_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    point_x <= px;
    point_y <= py;
    last_point <= last;
    point_valid <= 1'b1;
    do @(posedge clk); while (point_stall);
    fold_point(px, py, last);
    points_sent++;
  endtask

  // Drop the point stream and wait until every box is in, plus the pipeline depth
  task automatic settle();
    point_valid <= 1'b0;
    while (expected_boxes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Present one register write and hold it until it transfers; caller drops valid
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_COS) cos_q30 = data;
    else if (idx == REG_SIN) sin_q30 = data;
  endtask

  task automatic set_angle(input logic [31:0] c, input logic [31:0] s);
    settle();
    write_reg(REG_COS, c);
    write_reg(REG_SIN, s);
    cfg_valid <= 1'b0;
    angles_used++;
  endtask

  function automatic logic [31:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom;
    if (r < 7) return $urandom_range(0, 2000) - 1000;
    if (r < 9) return $signed($urandom) >>> $urandom_range(0, 30);
    case ($urandom_range(0, 3))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  // Mostly short sets, a few single points, some long ones
  function automatic int set_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 1;
    if (r < 85) return $urandom_range(2, 8);
    return $urandom_range(9, 60);
  endfunction

  // Axis rotations, diagonals, common angles, then random settings
  function automatic void pick_angle(input int phase, output logic [31:0] c,
                                     output logic [31:0] s);
    case (phase)
      0: begin c = '0; s = Q30_ONE; end
      1: begin c = Q30_MINUS_ONE; s = '0; end
      2: begin c = Q30_MINUS_ONE; s = Q30_MINUS_ONE; end
      3: begin c = Q30_ONE; s = Q30_ONE; end
      4: begin c = Q30_COS_45; s = Q30_COS_45; end
      5: begin c = Q30_COS_30; s = Q30_HALF; end
      6: begin c = Q30_HALF; s = Q30_MINUS_HALF; end
      7: begin c = $urandom; s = $urandom; end
      default: begin
        c = $urandom_range(0, 32'h8000_0000) - Q30_ONE;
        s = $urandom_range(0, 32'h8000_0000) - Q30_ONE;
      end
    endcase
  endfunction

  // Reset angle is the identity: coordinate extremes pass straight through
  task automatic test_identity_extremes();
    send_point(WORD_MAX, WORD_MIN, 1'b1);
    send_point(WORD_MIN, WORD_MAX, 1'b0);
    send_point('0, '0, 1'b0);
    send_point('1, 32'd1, 1'b1);
  endtask

  // Half scale makes odd sums land exactly between two integers
  task automatic test_half_ties();
    set_angle(Q30_HALF, '0);
    send_point(32'd1, '1, 1'b0);
    send_point('1, 32'd3, 1'b0);
    send_point(32'd3, -32'sd3, 1'b1);
    set_angle(Q30_HALF, Q30_HALF);
    send_point(32'd2, 32'd1, 1'b1);
  endtask

  // Drive the rotated value past the 33-bit range on both sides
  task automatic test_saturation();
    set_angle(Q30_MINUS_ONE, Q30_ONE);
    send_point(WORD_MIN, WORD_MIN, 1'b1);
    set_angle(WORD_MIN, WORD_MIN);
    send_point(WORD_MIN, WORD_MIN, 1'b0);
    send_point(WORD_MAX, WORD_MAX, 1'b1);
    set_angle(WORD_MAX, WORD_MAX);
    send_point(WORD_MAX, WORD_MIN, 1'b1);
  endtask

  // Writes to undecoded indexes must leave the angle alone
  task automatic test_unknown_register();
    set_angle('0, Q30_ONE);
    settle();
    write_reg(IDX_SPARE, 32'hFFFF_FFFF);
    write_reg(IDX_TOP, '0);
    cfg_valid <= 1'b0;
    send_point(32'd5, 32'd7, 1'b0);
    send_point(-32'sd3, 32'd2, 1'b1);
  endtask

  // Random sets under a new angle per phase, with varied idling on each side
  task automatic test_random_sets();
    logic [31:0] c, s;
    int left, run_len;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      pick_angle(phase, c, s);
      set_angle(c, s);
      point_idle_en = (phase % 4) < 2;
      box_idle_en = (phase % 2) == 0;
      left = POINTS_PER_PHASE;
      while (left > 0) begin
        run_len = set_length();
        for (int i = 0; i < run_len && left > 0; i++) begin
          send_point(rand_coord(), rand_coord(), i == run_len - 1);
          left--;
        end
      end
    end
  endtask

  // Stall the box side now and then
  initial begin : drive_box_stall
    int n;
    forever begin
      @(posedge clk);
      if (box_idle_en && $urandom_range(0, 3) == 0) begin
        n = idle_gap();
        if (n > 0) begin
          box_stall <= 1'b1;
          repeat (n) @(posedge clk);
          box_stall <= 1'b0;
        end
      end
    end
  end

  // Compare each box transfer with the oldest closed set
  always @(posedge clk) begin : check_boxes
    box_t got, want;
    if (!rst && box_valid && !box_stall) begin
      got = '{box_min_x, box_min_y, box_max_x, box_max_y};
      if (expected_boxes.size() == 0) begin
        note_error($sformatf("box with no closed set: min (%0d,%0d) max (%0d,%0d)",
                             got.min_x, got.min_y, got.max_x, got.max_y));
      end else begin
        want = expected_boxes.pop_front();
        boxes_checked++;
        if (got != want) begin
          note_error($sformatf("box expected min (%0d,%0d) max (%0d,%0d), got min (%0d,%0d) max (%0d,%0d)",
                               want.min_x, want.min_y, want.max_x, want.max_y,
                               got.min_x, got.min_y, got.max_x, got.max_y));
        end
      end
    end
  end

  // End the run if nothing transfers for too long
  always @(posedge clk) begin
    if (rst || (point_valid && !point_stall) || (box_valid && !box_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d boxes outstanding",
               idle_cycles, expected_boxes.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : run_tests
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_identity_extremes();
    test_half_ties();
    test_saturation();
    test_unknown_register();
    test_random_sets();
    settle();
    $display("summary: %0d points, %0d boxes checked, %0d angle settings",
             points_sent, boxes_checked, angles_used);
    $display("summary: rounding ties, saturation, undecoded writes, random idling; %0d errors",
             errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
sv/rbb_pkg.sv
sv/rbb_front.sv
sv/rbb_queue.sv
sv/rbb_back.sv
sv/rotated_bounding_box_top.sv
tb/sv/tb_rotated_bounding_box_top.sv
